// ===== hdl/window_receiver_cumulative_ack_unit_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef WINDOW_RECEIVER_CUMULATIVE_ACK_UNIT_DEFINES_SVH
`define WINDOW_RECEIVER_CUMULATIVE_ACK_UNIT_DEFINES_SVH

// same-cycle implication
`define WRCA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wrca check failed");

// next-cycle implication
`define WRCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wrca check failed");

`endif

// ===== hdl/wrca_pkg.sv =====
// ----------------------------------------------------------------------------
// wrca_pkg
// Shared types and constants of the cumulative ack receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package wrca_pkg;

   localparam int SEQ_WIDTH       = 16;
   localparam int ACK_WIDTH       = 17;
   localparam int WS_WIDTH        = 6;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_SIZE   = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MESSAGE_COUNT = 8'd1;

   localparam logic [WS_WIDTH-1:0]  WINDOW_SIZE_RESET   = 6'd1;
   localparam logic [SEQ_WIDTH-1:0] MESSAGE_COUNT_RESET = 16'd20000;

   typedef struct packed {
      logic [SEQ_WIDTH-1:0] seq;
      logic                 in_range;   // seq below message_count
   } front_item_type;

   typedef struct packed {
      logic signed [ACK_WIDTH-1:0] ack;
      logic                        complete;
   } rsp_item_type;

   typedef struct packed {
      logic [WS_WIDTH-1:0]  window_size;
      logic [SEQ_WIDTH-1:0] message_count;
   } cfg_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

`default_nettype wire

// ===== hdl/window_receiver_cumulative_ack_unit.sv =====
// ----------------------------------------------------------------------------
// window_receiver_cumulative_ack_unit
// Receive window with cumulative ack: one ack per received sequence number.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_seq_number                          req_push / req_full
//  response  rsp_ack_number, rsp_transfer_complete   rsp_pop / rsp_empty
//  csr       csr_index, csr_data                     csr_valid / csr_ready
//
// A request is popped in S_IDLE and answered from S_RESULT; one at the expected
// number also scans forward, passing S_SCAN_RD and S_SCAN_WT for each ring slot
// it reads from the slot memory, until an unmarked slot or message_count.
// After reset the slot ring is cleared one slot at a time; req_full is high.
// Request and response queues are two deep, so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module window_receiver_cumulative_ack_unit
   import wrca_pkg::*;
#(
   parameter int WINDOW_SLOTS = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   input  wire logic [SEQ_WIDTH-1:0]       req_seq_number,
   output logic                            req_full,
   input  wire logic                       rsp_pop,
   output logic                            rsp_empty,
   output logic signed [ACK_WIDTH-1:0]     rsp_ack_number,
   output logic                            rsp_transfer_complete,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type         cfg;
   back_status_type status;
   front_item_type  q_item;
   logic            q_empty, q_pop;
   logic            rsp_full, rsp_push;
   rsp_item_type    rsp_in, rsp_out;

   wrca_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_seq_number (req_seq_number),
      .req_full       (req_full),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .status         (status),
      .cfg            (cfg),
      .q_pop          (q_pop),
      .q_item         (q_item),
      .q_empty        (q_empty)
   );

   wrca_back #(
      .WINDOW_SLOTS (WINDOW_SLOTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .status   (status),
      .q_empty  (q_empty),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp_item (rsp_in)
   );

   wrca_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_out),
      .empty     (rsp_empty)
   );

   assign rsp_ack_number        = rsp_out.ack;
   assign rsp_transfer_complete = rsp_out.complete;

endmodule

`default_nettype wire

// ===== hdl/wrca_fifo.sv =====
// ----------------------------------------------------------------------------
// wrca_fifo
// Small synchronous queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
`default_nettype none

module wrca_fifo #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/wrca_front.sv =====
// ----------------------------------------------------------------------------
// wrca_front
// Config registers, request intake and range classification, request queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wrca_front
   import wrca_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   input  wire logic [SEQ_WIDTH-1:0]       req_seq_number,
   output logic                            req_full,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  wire back_status_type            status,
   output cfg_type                         cfg,
   input  wire logic                       q_pop,
   output front_item_type                  q_item,
   output logic                            q_empty
);

   logic [WS_WIDTH-1:0]  window_size_ff, window_size_in;
   logic [SEQ_WIDTH-1:0] message_count_ff, message_count_in;
   logic                 fifo_full;
   front_item_type       item;

   assign csr_ready = 1'b1;

   always_comb begin
      window_size_in   = window_size_ff;
      message_count_in = message_count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE:   window_size_in   = csr_data[WS_WIDTH-1:0];
            CSR_MESSAGE_COUNT: message_count_in = csr_data[SEQ_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff   <= WINDOW_SIZE_RESET;
         message_count_ff <= MESSAGE_COUNT_RESET;
      end else begin
         window_size_ff   <= window_size_in;
         message_count_ff <= message_count_in;
      end
   end

   assign cfg.window_size   = window_size_ff;
   assign cfg.message_count = message_count_ff;

   assign item.seq      = req_seq_number;
   assign item.in_range = (req_seq_number < message_count_ff);

   // no intake while the slot ring is being cleared
   assign req_full = fifo_full || status.clearing;

   wrca_fifo #(
      .WIDTH ($bits(front_item_type)),
      .DEPTH (2)
   ) u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !req_full),
      .push_data (item),
      .full      (fifo_full),
      .pop       (q_pop),
      .pop_data  (q_item),
      .empty     (q_empty)
   );

endmodule

`default_nettype wire

// ===== hdl/wrca_back.sv =====
// ----------------------------------------------------------------------------
// wrca_back
// Window engine: marks arrivals in the slot ring and scans the expected
// number forward over consecutive marks.
// ----------------------------------------------------------------------------
`default_nettype none

module wrca_back
   import wrca_pkg::*;
#(
   parameter int WINDOW_SLOTS = 64
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cfg_type        cfg,
   output back_status_type     status,
   input  wire logic           q_empty,
   input  wire front_item_type q_item,
   output logic                q_pop,
   input  wire logic           rsp_full,
   output logic                rsp_push,
   output rsp_item_type        rsp_item
);

   localparam int SW = $clog2(WINDOW_SLOTS);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_SCAN_RD = 3'd2;
   localparam logic [2:0] S_SCAN_WT = 3'd3;
   localparam logic [2:0] S_RESULT  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [SEQ_WIDTH-1:0] exp_ff, exp_in;
   logic [SW-1:0]        ptr_ff, ptr_in;      // exp_ff modulo WINDOW_SLOTS
   logic [SW-1:0]        clr_ff, clr_in;
   logic                 slot_mem [WINDOW_SLOTS];
   logic                 rd_ff;

   logic                 mem_we, mem_wd;
   logic [SW-1:0]        mem_addr;
   logic [SEQ_WIDTH-1:0] gap;
   logic [SW:0]          mark_sum;
   logic [SW-1:0]        mark_slot, ptr_next;
   logic                 in_window;

   assign gap       = q_item.seq - exp_ff;
   assign in_window = (q_item.seq > exp_ff)
                   && (gap <= {{(SEQ_WIDTH-WS_WIDTH){1'b0}}, cfg.window_size})
                   && (gap < SEQ_WIDTH'(WINDOW_SLOTS));
   assign mark_sum  = {1'b0, ptr_ff} + {1'b0, gap[SW-1:0]};
   assign mark_slot = (mark_sum >= (SW+1)'(WINDOW_SLOTS))
                    ? SW'(mark_sum - (SW+1)'(WINDOW_SLOTS)) : mark_sum[SW-1:0];
   assign ptr_next  = (ptr_ff == SW'(WINDOW_SLOTS - 1)) ? '0 : ptr_ff + SW'(1);

   always_comb begin
      state_in = state_ff;
      exp_in   = exp_ff;
      ptr_in   = ptr_ff;
      clr_in   = clr_ff;
      mem_we   = 1'b0;
      mem_wd   = 1'b0;
      mem_addr = ptr_ff;
      q_pop    = 1'b0;
      rsp_push = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + SW'(1);
            if (clr_ff == SW'(WINDOW_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_item.in_range && (q_item.seq == exp_ff)) begin
                  // take the expected packet in and step past it
                  mem_we   = 1'b1;
                  exp_in   = exp_ff + SEQ_WIDTH'(1);
                  ptr_in   = ptr_next;
                  state_in = S_SCAN_RD;
               end else if (q_item.in_range && in_window) begin
                  mem_we   = 1'b1;
                  mem_wd   = 1'b1;
                  mem_addr = mark_slot;
                  state_in = S_RESULT;
               end else begin
                  state_in = S_RESULT;
               end
            end
         end
         S_SCAN_RD: begin
            state_in = (exp_ff < cfg.message_count) ? S_SCAN_WT : S_RESULT;
         end
         S_SCAN_WT: begin
            if (rd_ff) begin
               mem_we   = 1'b1;
               exp_in   = exp_ff + SEQ_WIDTH'(1);
               ptr_in   = ptr_next;
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         exp_ff   <= '0;
         ptr_ff   <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         exp_ff   <= exp_in;
         ptr_ff   <= ptr_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_addr] <= mem_wd;
      end
      rd_ff <= slot_mem[mem_addr];
   end

   assign rsp_item.ack      = $signed({1'b0, exp_ff}) - ACK_WIDTH'(1);
   assign rsp_item.complete = (exp_ff >= cfg.message_count);
   assign status.clearing   = (state_ff == S_CLEAR);

endmodule

`default_nettype wire

// ===== hdl/wrca_checker.sv =====
// ----------------------------------------------------------------------------
// wrca_checker
// Port-level checks of the cumulative ack receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "window_receiver_cumulative_ack_unit_defines.svh"

module wrca_checker
   import wrca_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_full,
   input wire logic                   rsp_pop,
   input wire logic                   rsp_empty,
   input wire logic signed [ACK_WIDTH-1:0] rsp_ack_number
);

   logic signed [ACK_WIDTH-1:0] last_ack_ff;

   // last ack handed out; acks never go backward
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ack_ff <= '1;
      end else if (rsp_pop && !rsp_empty) begin
         last_ack_ff <= rsp_ack_number;
      end
   end

   `WRCA_ASSERT_NEXT(a_full_after_reset, clock, 1'b0, reset, req_full)
   `WRCA_ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, rsp_empty)
   `WRCA_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_ack_number))
   `WRCA_ASSERT_IMPLY(a_ack_monotonic, clock, reset, rsp_pop && !rsp_empty, rsp_ack_number >= last_ack_ff)

endmodule

bind window_receiver_cumulative_ack_unit wrca_checker u_wrca_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_pop        (rsp_pop),
   .rsp_empty      (rsp_empty),
   .rsp_ack_number (rsp_ack_number)
);

`default_nettype wire

// ===== bench/window_receiver_cumulative_ack_unit_test.sv =====
// ----------------------------------------------------------------------------
// window_receiver_cumulative_ack_unit_test
// Sends sequence numbers in order, reordered, duplicated and out of range
// through the receive window, tracks the cumulative ack in a local model and
// checks each response field; both queues idle at random in several phases.
// ----------------------------------------------------------------------------
module window_receiver_cumulative_ack_unit_test;
   import wrca_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD   = 10;
   localparam int WINDOW_SLOTS   = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 200;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic [SEQ_WIDTH-1:0]       req_seq_number = '0;
   logic                       req_full;
   logic                       rsp_pop = 1'b0;
   logic                       rsp_empty;
   logic signed [ACK_WIDTH-1:0] rsp_ack_number;
   logic                       rsp_transfer_complete;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // receive window model
   int                         next_seq = 0;
   bit [WINDOW_SLOTS-1:0]      arrived = '0;
   logic [WS_WIDTH-1:0]        win = WINDOW_SIZE_RESET;
   logic [SEQ_WIDTH-1:0]       msg_count = MESSAGE_COUNT_RESET;

   rsp_item_type               pending_acks[$];
   int                         mismatch_count = 0;
   int                         stall_cycles = 0;
   int                         sender_idle_pct = 0;
   int                         receiver_idle_pct = 0;

   window_receiver_cumulative_ack_unit #(
      .WINDOW_SLOTS(WINDOW_SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_seq_number(req_seq_number),
      .req_full(req_full),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_ack_number(rsp_ack_number),
      .rsp_transfer_complete(rsp_transfer_complete),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Updates the window for one received packet and returns the ack it yields.
   function automatic rsp_item_type ack_after_packet(input logic [SEQ_WIDTH-1:0] seq);
      rsp_item_type ack;
      int gap;
      if (seq < msg_count) begin
         if (int'(seq) == next_seq) begin
            arrived[seq % WINDOW_SLOTS] = 1'b1;
            while (next_seq < int'(msg_count) && arrived[next_seq % WINDOW_SLOTS]) begin
               arrived[next_seq % WINDOW_SLOTS] = 1'b0;
               next_seq++;
            end
         end else if (int'(seq) > next_seq) begin
            gap = int'(seq) - next_seq;
            if (gap <= int'(win) && gap < WINDOW_SLOTS) begin
               arrived[seq % WINDOW_SLOTS] = 1'b1;
            end
         end
      end
      ack.ack = ACK_WIDTH'(next_seq - 1);
      ack.complete = (next_seq >= int'(msg_count));
      return ack;
   endfunction

   // Mostly in-window traffic, with old, out-of-window and stray numbers mixed in.
   function automatic logic [SEQ_WIDTH-1:0] random_packet_seq();
      int roll;
      int seq;
      roll = $urandom_range(99);
      if (roll < 20) begin
         seq = next_seq;
      end else if (roll < 68) begin
         seq = next_seq + $urandom_range((win == 0) ? 1 : int'(win), 1);
      end else if (roll < 76) begin
         seq = next_seq - $urandom_range(6, 1);
      end else if (roll < 84) begin
         seq = next_seq + int'(win) + $urandom_range(3, 1);
      end else if (roll < 92) begin
         seq = int'(msg_count) + $urandom_range(3);
      end else begin
         seq = $urandom_range(65535);
      end
      return SEQ_WIDTH'(seq);
   endfunction

   task automatic wait_acks_drained();
      while (pending_acks.size() != 0) @(posedge clock);
   endtask

   task automatic push_seq(input logic [SEQ_WIDTH-1:0] seq);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_seq_number <= seq;
      do @(posedge clock); while (req_full);
      pending_acks.push_back(ack_after_packet(seq));
   endtask

   // Writes the selected registers once the block has gone idle.
   task automatic write_config(input bit set_ws, input logic [WS_WIDTH-1:0] ws,
                               input bit set_mc, input logic [SEQ_WIDTH-1:0] mc,
                               input bit add_unknown);
      req_push <= 1'b0;
      wait_acks_drained();
      if (set_ws) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_WINDOW_SIZE;
         // upper data bits are don't-care for the window size
         csr_data  <= {10'($urandom), ws};
         do @(posedge clock); while (!csr_ready);
         win = ws;
      end
      if (set_mc) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_MESSAGE_COUNT;
         csr_data  <= mc;
         do @(posedge clock); while (!csr_ready);
         msg_count = mc;
      end
      if (add_unknown) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_INDEX_WIDTH'($urandom_range(255, 2));
         csr_data  <= CSR_DATA_WIDTH'($urandom);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_zero_message_count();
      write_config(1'b1, 6'd0, 1'b1, 16'd0, 1'b1);
      push_seq(16'd0);
      push_seq(16'hFFFF);
   endtask

   task automatic test_default_window();
      int b;
      write_config(1'b1, WINDOW_SIZE_RESET, 1'b1, MESSAGE_COUNT_RESET, 1'b0);
      b = next_seq;
      push_seq(SEQ_WIDTH'(b));
      push_seq(SEQ_WIDTH'(b + 2));
      push_seq(SEQ_WIDTH'(b + 3));
      push_seq(SEQ_WIDTH'(b + 1));
   endtask

   task automatic test_zero_window();
      int b;
      b = next_seq;
      write_config(1'b1, 6'd0, 1'b1, SEQ_WIDTH'(b + 6), 1'b0);
      push_seq(SEQ_WIDTH'(b + 1));
      push_seq(SEQ_WIDTH'(b));
      push_seq(SEQ_WIDTH'(b + 1));
   endtask

   task automatic test_transfer_end();
      int b;
      b = next_seq;
      write_config(1'b1, 6'd63, 1'b1, SEQ_WIDTH'(b + 4), 1'b0);
      push_seq(SEQ_WIDTH'(b + 63));
      push_seq(SEQ_WIDTH'(b + 3));
      push_seq(SEQ_WIDTH'(b + 1));
      push_seq(SEQ_WIDTH'(b + 2));
      push_seq(SEQ_WIDTH'(b));
      push_seq(SEQ_WIDTH'(b + 4));
   endtask

   // Marks survive a drop of the message count and feed the scan after a raise.
   task automatic test_message_count_change();
      int b;
      b = next_seq;
      write_config(1'b1, 6'd63, 1'b1, SEQ_WIDTH'(b + 40), 1'b0);
      push_seq(SEQ_WIDTH'(b + 64));
      push_seq(SEQ_WIDTH'(b + 63));
      push_seq(SEQ_WIDTH'(b + 1));
      push_seq(SEQ_WIDTH'(b + 5));
      write_config(1'b0, 6'd0, 1'b1, SEQ_WIDTH'(b + 2), 1'b0);
      push_seq(SEQ_WIDTH'(b));
      push_seq(SEQ_WIDTH'(b + 2));
      write_config(1'b0, 6'd0, 1'b1, SEQ_WIDTH'(b + 70), 1'b0);
      push_seq(SEQ_WIDTH'(b + 1));
      push_seq(SEQ_WIDTH'(b + 4));
      push_seq(SEQ_WIDTH'(b + 3));
      push_seq(SEQ_WIDTH'(b + 2));
   endtask

   task automatic test_reordered_transfers(input int item_goal, input int sender_pct,
                                           input int receiver_pct);
      int sent;
      int budget;
      int pick;
      int top;
      logic [WS_WIDTH-1:0] ws;
      logic [SEQ_WIDTH-1:0] mc;
      sender_idle_pct   = sender_pct;
      receiver_idle_pct = receiver_pct;
      sent = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(9);
         ws = (pick == 0) ? 6'd0 : (pick == 1) ? 6'd63 : (pick == 2) ? 6'd1
            : WS_WIDTH'($urandom_range(63));
         top = next_seq + $urandom_range(60, 4);
         mc = (top > 65535 || $urandom_range(11) == 0) ? 16'hFFFF : SEQ_WIDTH'(top);
         write_config(1'b1, ws, 1'b1, mc, $urandom_range(7) == 0);
         budget = $urandom_range(60, 10);
         for (int k = 0; k < budget && next_seq < int'(msg_count); k++) begin
            push_seq(random_packet_seq());
            sent++;
         end
      end
   endtask

   // Fills the whole window in random order, then the expected number: longest scan.
   task automatic test_full_window_scan();
      int b;
      int order[WINDOW_SLOTS-1];
      int j;
      int swap;
      b = next_seq;
      write_config(1'b1, 6'd63, 1'b1, SEQ_WIDTH'(b + 64 + $urandom_range(40)), 1'b0);
      for (int i = 0; i < WINDOW_SLOTS - 1; i++) order[i] = i + 1;
      for (int i = WINDOW_SLOTS - 2; i > 0; i--) begin
         j = $urandom_range(i);
         swap = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      for (int i = 0; i < WINDOW_SLOTS - 1; i++) push_seq(SEQ_WIDTH'(b + order[i]));
      push_seq(SEQ_WIDTH'(b));
   endtask

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_acks.size() == 0) begin
            $display("%0t: response with no request waiting: ack_number %0d complete %0b",
                     $time, rsp_ack_number, rsp_transfer_complete);
            mismatch_count++;
         end else begin
            want = pending_acks.pop_front();
            if (rsp_ack_number !== want.ack) begin
               $display("%0t: ack_number expected %0d, actual %0d",
                        $time, $signed(want.ack), rsp_ack_number);
               mismatch_count++;
            end
            if (rsp_transfer_complete !== want.complete) begin
               $display("%0t: transfer_complete expected %0b, actual %0b",
                        $time, want.complete, rsp_transfer_complete);
               mismatch_count++;
            end
         end
      end
   end

   // ends the run after too long without any handshake
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("window_receiver_cumulative_ack_unit_test NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      sender_idle_pct   = 22;
      receiver_idle_pct = 59;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_zero_message_count();
      test_default_window();
      test_zero_window();
      test_transfer_end();
      test_message_count_change();

      test_reordered_transfers(200, 22, 59);
      test_reordered_transfers(200, 59, 22);
      test_reordered_transfers(190, 0, 0);
      test_full_window_scan();

      req_push <= 1'b0;
      wait_acks_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("window_receiver_cumulative_ack_unit_test OK");
      end else begin
         $display("window_receiver_cumulative_ack_unit_test NOT OK");
      end
      $finish;
   end

endmodule
